// ----- src/bbfe_pkg.sv -----
package bbfe_pkg;

  // table geometry
  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W       = CNT_W + 1;

  // payload widths
  localparam int ID_W    = 32;
  localparam int DIM_W   = 16;
  localparam int COST_W  = 35;
  localparam int BYTES_W = 48;

  // configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 64;
  localparam logic [BYTES_W-1:0] BUDGET_RST = BYTES_W'(268435456);

  // register index, taken from paddr above the 8-byte slot
  typedef enum logic [PADDR_W-4:0] {
    REG_BUDGET = 1'b0
  } reg_idx_e;

  typedef enum logic {
    ACT_ADMIT   = 1'b0,
    ACT_RELEASE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    KIND_EVICT   = 2'd0,
    KIND_ADMIT   = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_e;

  // read address selection for the table memory
  typedef enum logic [1:0] {
    RD_HEAD      = 2'd0,
    RD_HEAD_NEXT = 2'd1,
    RD_IDX_NEXT  = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [COST_W-1:0] size;
  } entry_t;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic    cap_in;
    logic    cost_ld;
    logic    evict;
    logic    admit_out;
    logic    scan_next;
    logic    found;
    logic    shift_step;
    logic    shift_done;
    logic    rel_out;
    rd_sel_e rd_sel;
  } ctrl_cmd_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic in_release;
    logic out_free;
    logic need_evict;
    logic scan_end;
    logic id_match;
  } dp_status_t;

  // physical slot of a logical offset from the oldest entry (ring wrap)
  function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(MAX_ENTRIES)) begin
      s = s - SUM_W'(MAX_ENTRIES);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// ----- src/byte_budget_fifo_eviction_top.sv -----
// admit: the request is captured, its cost loaded, then the oldest entry is
//   evicted while over budget or full, one result each, before the admit result
// release: a search from the oldest entry, then compaction of the younger entries
//   (search then compaction share one pass over the table memory)
// one request in flight at a time; a stalled output holds the sequencer
// reset: table empty, byte total zero, budget 2^28; table memory not cleared
module byte_budget_fifo_eviction_top import bbfe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [ID_W-1:0]    entry_id_i,
  input  logic [DIM_W-1:0]   width_i,
  input  logic [DIM_W-1:0]   height_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [ID_W-1:0]    result_id_o,
  output logic               accepted_o,
  output logic [BYTES_W-1:0] total_bytes_o,
  output logic               last_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [BYTES_W-1:0] budget;
  ctrl_cmd_t          cmd;
  dp_status_t         st;

  bbfe_csr u_csr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .budget_o (budget)
  );

  bbfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  bbfe_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .action_i      (action_i),
    .entry_id_i    (entry_id_i),
    .width_i       (width_i),
    .height_i      (height_i),
    .budget_i      (budget),
    .cmd_i         (cmd),
    .st_o          (st),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .result_id_o   (result_id_o),
    .accepted_o    (accepted_o),
    .total_bytes_o (total_bytes_o),
    .last_o        (last_o)
  );

endmodule

// ----- src/bbfe_csr.sv -----
module bbfe_csr import bbfe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [BYTES_W-1:0] budget_o
);

  logic [BYTES_W-1:0] budget_q, budget_d;
  reg_idx_e           reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite && pready;

  // budget register write
  always_comb begin
    budget_d = budget_q;
    if (wr_en && reg_idx == REG_BUDGET) begin
      budget_d = pwdata[BYTES_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= BUDGET_RST;
    end else begin
      budget_q <= budget_d;
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_BUDGET: prdata = PDATA_W'(budget_q);
      default:    prdata = '0;
    endcase
  end

  assign budget_o = budget_q;

endmodule

// ----- src/bbfe_dp.sv -----
module bbfe_dp import bbfe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               action_i,
  input  logic [ID_W-1:0]    entry_id_i,
  input  logic [DIM_W-1:0]   width_i,
  input  logic [DIM_W-1:0]   height_i,
  input  logic [BYTES_W-1:0] budget_i,
  input  ctrl_cmd_t          cmd_i,
  output dp_status_t         st_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [ID_W-1:0]    result_id_o,
  output logic               accepted_o,
  output logic [BYTES_W-1:0] total_bytes_o,
  output logic               last_o
);

  // captured request
  logic [ID_W-1:0]    id_q;
  logic [DIM_W-1:0]   w_q, h_q;
  logic [COST_W-1:0]  cost_q;

  // table state
  logic [IDX_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [BYTES_W-1:0] bytes_q, bytes_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic               found_q, found_d;

  // table memory
  entry_t             mem [MAX_ENTRIES];
  entry_t             rd_data_q, wr_data;
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  logic               wr_en;

  // result register
  logic               out_valid_q, out_valid_d;
  kind_e              out_kind_q, out_kind_d;
  logic [ID_W-1:0]    out_id_q, out_id_d;
  logic               out_acc_q, out_acc_d;
  logic [BYTES_W-1:0] out_total_q;
  logic               out_last_q, out_last_d;

  logic [BYTES_W:0]   sum_ext;
  logic               over;
  logic               emit;
  logic [2*DIM_W-1:0] area;

  // budget and table-full check for the pending admit
  assign sum_ext = (BYTES_W+1)'(bytes_q) + (BYTES_W+1)'(cost_q);
  assign over    = (sum_ext > (BYTES_W+1)'(budget_i)) ||
                   (count_q >= CNT_W'(MAX_ENTRIES));
  assign area    = w_q * h_q;
  assign emit    = cmd_i.evict || cmd_i.admit_out || cmd_i.rel_out;

  // status
  assign st_o.in_release = (action_e'(action_i) == ACT_RELEASE);
  assign st_o.out_free   = !out_valid_q || !out_stall_i;
  assign st_o.need_evict = (count_q != '0) && over;
  assign st_o.scan_end   = (idx_q >= count_q);
  assign st_o.id_match   = (rd_data_q.id == id_q);

  // read address
  always_comb begin
    case (cmd_i.rd_sel)
      RD_HEAD:      rd_addr = head_q;
      RD_HEAD_NEXT: rd_addr = wrap_add(head_q, CNT_W'(1));
      RD_IDX_NEXT:  rd_addr = wrap_add(head_q, idx_q + CNT_W'(1));
      default:      rd_addr = head_q;
    endcase
  end

  // table bookkeeping and memory writes
  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    bytes_d    = bytes_q;
    idx_d      = idx_q;
    found_d    = found_q;
    wr_en      = 1'b0;
    wr_addr    = wrap_add(head_q, count_q);
    wr_data    = rd_data_q;
    out_kind_d = out_kind_q;
    out_id_d   = out_id_q;
    out_acc_d  = 1'b0;
    out_last_d = 1'b1;
    if (cmd_i.cap_in) begin
      idx_d   = '0;
      found_d = 1'b0;
    end
    // pop the oldest entry
    if (cmd_i.evict) begin
      head_d     = wrap_add(head_q, CNT_W'(1));
      count_d    = count_q - CNT_W'(1);
      bytes_d    = bytes_q - BYTES_W'(rd_data_q.size);
      out_kind_d = KIND_EVICT;
      out_id_d   = rd_data_q.id;
      out_last_d = 1'b0;
    end
    // admit outcome, push at the young end when it fits
    if (cmd_i.admit_out) begin
      out_kind_d = KIND_ADMIT;
      out_id_d   = id_q;
      out_acc_d  = !over;
      if (!over) begin
        wr_en        = 1'b1;
        wr_data.id   = id_q;
        wr_data.size = cost_q;
        count_d      = count_q + CNT_W'(1);
        bytes_d      = sum_ext[BYTES_W-1:0];
      end
    end
    // release search
    if (cmd_i.scan_next) begin
      idx_d = idx_q + CNT_W'(1);
    end
    if (cmd_i.found) begin
      idx_d   = idx_q + CNT_W'(1);
      found_d = 1'b1;
      bytes_d = bytes_q - BYTES_W'(rd_data_q.size);
    end
    // close the gap one slot per cycle
    if (cmd_i.shift_step) begin
      wr_en   = 1'b1;
      wr_addr = wrap_add(head_q, idx_q - CNT_W'(1));
      idx_d   = idx_q + CNT_W'(1);
    end
    if (cmd_i.shift_done) begin
      count_d = count_q - CNT_W'(1);
    end
    if (cmd_i.rel_out) begin
      out_kind_d = KIND_RELEASE;
      out_id_d   = id_q;
      out_acc_d  = found_q;
    end
  end

  // result valid
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      bytes_q     <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      bytes_q     <= bytes_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      id_q <= entry_id_i;
      w_q  <= width_i;
      h_q  <= height_i;
    end
    if (cmd_i.cost_ld) begin
      cost_q <= COST_W'({area, 2'b00});
    end
    if (emit) begin
      out_kind_q  <= out_kind_d;
      out_id_q    <= out_id_d;
      out_acc_q   <= out_acc_d;
      out_total_q <= bytes_d;
      out_last_q  <= out_last_d;
    end
  end

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign result_id_o   = out_id_q;
  assign accepted_o    = out_acc_q;
  assign total_bytes_o = out_total_q;
  assign last_o        = out_last_q;

  // resident count stays within the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ENTRIES))
    else $error("resident count above table size");

  // a result is only loaded when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrites a pending result");

  // eviction only from a non-empty table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.evict |-> (count_q != '0))
    else $error("eviction from empty table");

  // end of compaction drops exactly one entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_done |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("compaction did not remove one entry");

endmodule

// ----- src/bbfe_ctrl.sv -----
module bbfe_ctrl import bbfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t st_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_COST    = 6'b000010,
    S_CHECK   = 6'b000100,
    S_SEARCH  = 6'b001000,
    S_SHIFT   = 6'b010000,
    S_REL_OUT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // sequencer
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.rd_sel = RD_HEAD;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d      = st_i.in_release ? S_SEARCH : S_COST;
        end
      end
      S_COST: begin
        cmd_o.cost_ld = 1'b1;
        state_d       = S_CHECK;
      end
      // evict oldest while over budget or full, then report the admit
      S_CHECK: begin
        if (st_i.out_free) begin
          if (st_i.need_evict) begin
            cmd_o.evict  = 1'b1;
            cmd_o.rd_sel = RD_HEAD_NEXT;
          end else begin
            cmd_o.admit_out = 1'b1;
            state_d         = S_IDLE;
          end
        end
      end
      // walk from the oldest entry looking for the id
      S_SEARCH: begin
        cmd_o.rd_sel = RD_IDX_NEXT;
        if (st_i.scan_end) begin
          state_d = S_REL_OUT;
        end else if (st_i.id_match) begin
          cmd_o.found = 1'b1;
          state_d     = S_SHIFT;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      // move younger entries down over the removed slot
      S_SHIFT: begin
        cmd_o.rd_sel = RD_IDX_NEXT;
        if (st_i.scan_end) begin
          cmd_o.shift_done = 1'b1;
          state_d          = S_REL_OUT;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      S_REL_OUT: begin
        if (st_i.out_free) begin
          cmd_o.rel_out = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a request is only taken in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.cap_in) |-> (state_q == S_IDLE && in_valid_i))
    else $error("request captured outside idle");

  // a cost load is followed by the budget check, where evictions and the admit outcome are issued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.cost_ld) |=> (state_q == S_CHECK))
    else $error("cost load not followed by budget check");

  // state register stays one-hot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

endmodule
